// File: rtl/msp_pkg.sv
// Package for the mass-spring step block: table sizes, codes, entry layouts
// and the saturating Q16.16 helpers. No dependencies.
package msp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_SPRINGS = 128;
  localparam int NODE_AW     = $clog2(MAX_NODES);
  localparam int SPR_AW      = $clog2(MAX_SPRINGS);

  typedef enum logic [1:0] {
    OP_NODE   = 2'd0,
    OP_SPRING = 2'd1,
    OP_STEP   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_GRAVITY    = 2'd1,
    REG_TERM_SPEED = 2'd2,
    REG_TIME_STEP  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [30:0] mass;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } node_t;

  typedef struct packed {
    logic signed [31:0] fy;
    logic signed [31:0] fx;
  } force_t;

  typedef struct packed {
    logic signed [31:0]  damping;
    logic signed [31:0]  stiffness;
    logic        [30:0]  brk;
    logic        [30:0]  rest;
    logic [NODE_AW-1:0]  n2;
    logic [NODE_AW-1:0]  n1;
  } spring_t;

  // request and response of the shared divide / square-root unit
  typedef struct packed {
    logic               is_sqrt;
    logic        [63:0] rad;
    logic signed [31:0] dvd;
    logic        [31:0] dvs;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } ds_rsp_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // product >> 16 (floor), saturated to 32 bits
  function automatic logic signed [31:0] qmul_res(input logic signed [63:0] p);
    logic signed [31:0] r;
    if ((&p[63:47]) || !(|p[63:47])) r = p[47:16];
    else r = p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return r;
  endfunction

endpackage

// File: rtl/msp_cmd_if.sv
// Input item channel of the mass-spring step block.
// Plain valid/ready handshake; no package dependency.
interface msp_cmd_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic        [6:0]  index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic        [30:0] mass;
  logic        [11:0] spring_ends;
  logic        [30:0] rest_length;
  logic        [30:0] break_length;
  logic signed [31:0] stiffness;
  logic signed [31:0] damping;

  modport source (output valid, op, index, pos_x, pos_y, vel_x, vel_y, mass,
                  spring_ends, rest_length, break_length, stiffness, damping,
                  input ready);
  modport sink   (input valid, op, index, pos_x, pos_y, vel_x, vel_y, mass,
                  spring_ends, rest_length, break_length, stiffness, damping,
                  output ready);
endinterface

// File: rtl/msp_res_if.sv
// Result item channel of the mass-spring step block.
// Plain valid/ready handshake; no package dependency.
interface msp_res_if;
  logic               valid;
  logic               ready;
  logic        [5:0]  node_index;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic        [7:0]  live_springs;
  logic               last;

  modport source (output valid, node_index, out_pos_x, out_pos_y, out_vel_x,
                  out_vel_y, live_springs, last, input ready);
  modport sink   (input valid, node_index, out_pos_x, out_pos_y, out_vel_x,
                  out_vel_y, live_springs, last, output ready);
endinterface

// File: rtl/msp_cfg_if.sv
// Configuration write channel: register index and write data.
// Plain valid/ready handshake; no package dependency.
interface msp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/msp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/msp_divsqrt.sv
// Shared iterative unit: Q16.16 divide (48 steps, truncating, saturated)
// or floor square root of a 64-bit value (32 steps). Uses msp_pkg.
module msp_divsqrt import msp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  ds_req_t req,
  output ds_rsp_t rsp
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t     state;
  logic        is_sqrt;
  logic        neg;
  logic        dvs_zero;
  logic [5:0]  cnt;
  logic [63:0] acc;
  logic [35:0] rem;
  logic [47:0] qr;
  logic [31:0] dvs;
  logic        done;
  logic [31:0] res;

  logic [35:0] rs_div;
  logic [35:0] rs_sq;
  logic [35:0] trial;
  logic [31:0] mag;

  assign rs_div = {rem[34:0], acc[63]};
  assign rs_sq  = {rem[33:0], acc[63:62]};
  assign trial  = {2'b00, qr[31:0], 2'b01};
  assign mag    = req.dvd[31] ? 32'(-req.dvd) : 32'(req.dvd);

  assign rsp.done = done;
  assign rsp.res  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            is_sqrt  <= req.is_sqrt;
            neg      <= req.dvd[31];
            dvs_zero <= (req.dvs == '0);
            dvs      <= req.dvs;
            rem      <= '0;
            qr       <= '0;
            if (req.is_sqrt) begin
              acc <= req.rad;
              cnt <= 6'd31;
            end else begin
              acc <= {mag, 32'd0} >> 0;
              cnt <= 6'd47;
            end
            acc <= req.is_sqrt ? req.rad : {mag, 32'd0};
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (is_sqrt) begin
            if (rs_sq >= trial) begin
              rem <= rs_sq - trial;
              qr  <= {qr[46:0], 1'b1};
            end else begin
              rem <= rs_sq;
              qr  <= {qr[46:0], 1'b0};
            end
            acc <= {acc[61:0], 2'b00};
          end else begin
            if (rs_div >= {4'd0, dvs}) begin
              rem <= rs_div - {4'd0, dvs};
              qr  <= {qr[46:0], 1'b1};
            end else begin
              rem <= rs_div;
              qr  <= {qr[46:0], 1'b0};
            end
            acc <= {acc[62:0], 1'b0};
          end
          if (cnt == '0) state <= D_FIN;
          else cnt <= cnt - 6'd1;
        end
        D_FIN: begin
          done  <= 1'b1;
          state <= D_IDLE;
          if (is_sqrt) res <= qr[31:0];
          else if (dvs_zero) res <= '0;
          else if (neg) res <= (qr > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-qr);
          else res <= (qr > 48'h0000_7fff_ffff) ? 32'h7fff_ffff : qr[31:0];
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/mass_spring_step.sv
// Top level of the mass-spring step block: node, force and spring tables in
// RAM, a sequencer, one 32x32 multiplier and the shared divide/sqrt unit.
// Uses msp_pkg, msp_cmd_if, msp_res_if, msp_cfg_if, msp_ram, msp_divsqrt.
//
//   channel  dir  carries
//   cmd      in   node write, spring write or step request
//   res      out  one node state per node in use, after a step
//   cfg      in   register writes (node count, gravity, terminal speed, dt)
//
// A step's time is set mostly by the shared iterative divide/sqrt unit:
// two divides per node in use, one square root per live spring and two
// divides per spring that holds, plus a move of the later entries when a
// spring breaks. One item at a time: cmd is only ready between steps.
// Synchronous reset clears control state, the force-valid bits and the
// live spring count; no clearing pass is needed. A stalled result simply
// holds the sequencer.
module mass_spring_step import msp_pkg::*; (
  input logic       clk,
  input logic       rst,
  msp_cmd_if.sink   cmd,
  msp_res_if.source res,
  msp_cfg_if.sink   cfg
);

  typedef enum logic [5:0] {
    ST_IDLE,
    N_RD, N_LD, N_DX, N_DY, N_M1, N_M2, N_M3, N_M4, N_M5, N_M6, N_WR,
    S_RD, S_LD, S_N1, S_N2, S_Q1, S_Q2, S_Q3, S_SQ, S_BRK, C_RD, C_WR,
    S_UX, S_UY, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8, S_E9, S_E10,
    O_RD, O_LD, O_WT
  } state_t;

  state_t state;

  // configuration
  logic        [6:0]  node_count;
  logic signed [31:0] gravity;
  logic        [30:0] term_speed;
  logic        [30:0] time_step;

  logic [7:0]           active;
  logic [MAX_NODES-1:0] frc_vld;
  logic [7:0]           cnt;
  logic [SPR_AW-1:0]    jdx;
  logic [6:0]           nc;

  // working registers
  logic signed [31:0] px, py, vx, vy;
  logic        [30:0] mass;
  logic signed [31:0] fry, ax, ay, fy_new;
  logic signed [31:0] dx, dy, rvx, rvy, ux, uy;
  logic signed [31:0] comp, dot, tmp, f, fx;
  logic        [63:0] sq_a;
  logic        [31:0] len;
  spring_t            spr;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] pq;
  logic signed [32:0] neg_term;

  // RAM ports
  logic               node_we, frc_we, spr_we;
  logic [NODE_AW-1:0] node_wa, node_ra, frc_wa, frc_ra;
  logic [SPR_AW-1:0]  spr_wa, spr_ra;
  node_t              node_wd, node_rd;
  force_t             frc_wd, frc_rd, frc_cur;
  spring_t            spr_wd, spr_rd;
  logic               frc_rv;

  // divide / sqrt unit
  logic    ds_start;
  ds_req_t ds_req;
  ds_rsp_t ds_rsp;

  // result register
  logic               r_valid;
  logic        [5:0]  r_index;
  node_t              r_node;
  logic        [7:0]  r_live;
  logic               r_last;

  logic cmd_acc;

  msp_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
    .raddr(node_ra), .rdata(node_rd)
  );

  msp_ram #(.WIDTH($bits(force_t)), .DEPTH(MAX_NODES)) u_frc_ram (
    .clk(clk), .we(frc_we), .waddr(frc_wa), .wdata(frc_wd),
    .raddr(frc_ra), .rdata(frc_rd)
  );

  msp_ram #(.WIDTH($bits(spring_t)), .DEPTH(MAX_SPRINGS)) u_spr_ram (
    .clk(clk), .we(spr_we), .waddr(spr_wa), .wdata(spr_wd),
    .raddr(spr_ra), .rdata(spr_rd)
  );

  msp_divsqrt u_ds (
    .clk(clk), .rst(rst), .start(ds_start), .req(ds_req), .rsp(ds_rsp)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  assign res.valid        = r_valid;
  assign res.node_index   = r_index;
  assign res.out_pos_x    = r_node.pos_x;
  assign res.out_pos_y    = r_node.pos_y;
  assign res.out_vel_x    = r_node.vel_x;
  assign res.out_vel_y    = r_node.vel_y;
  assign res.live_springs = r_live;
  assign res.last         = r_last;

  // node count beyond the table acts as the full table
  assign nc = (node_count > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count;

  // a force entry not written since reset reads as zero
  assign frc_cur  = frc_rv ? frc_rd : '0;
  assign pq       = qmul_res(prod);
  assign neg_term = 33'sd0 - $signed({2'b00, term_speed});

  // multiplier operands, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      N_M1: begin mul_a = ax; mul_b = $signed({1'b0, time_step}); end
      N_M2: begin mul_a = ay; mul_b = $signed({1'b0, time_step}); end
      N_M3: begin mul_a = vx; mul_b = $signed({1'b0, time_step}); end
      N_M4: begin mul_a = vy; mul_b = $signed({1'b0, time_step}); end
      N_M5: begin mul_a = $signed({1'b0, mass}); mul_b = gravity; end
      S_Q1: begin mul_a = dx; mul_b = dx; end
      S_Q2: begin mul_a = dy; mul_b = dy; end
      S_E1: begin mul_a = rvx; mul_b = ux; end
      S_E2: begin mul_a = rvy; mul_b = uy; end
      S_E3: begin mul_a = comp; mul_b = spr.stiffness; end
      S_E4: begin mul_a = dot; mul_b = spr.damping; end
      S_E6: begin mul_a = ux; mul_b = f; end
      S_E7: begin mul_a = uy; mul_b = f; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
    frc_rv <= frc_vld[frc_ra];
  end

  // RAM addressing and divide/sqrt requests
  always_comb begin
    node_we  = 1'b0;
    node_wa  = cmd.index[NODE_AW-1:0];
    node_wd  = '{mass: cmd.mass, vel_y: cmd.vel_y, vel_x: cmd.vel_x,
                 pos_y: cmd.pos_y, pos_x: cmd.pos_x};
    node_ra  = cnt[NODE_AW-1:0];
    frc_we   = 1'b0;
    frc_wa   = cnt[NODE_AW-1:0];
    frc_wd   = '{fy: fy_new, fx: '0};
    frc_ra   = cnt[NODE_AW-1:0];
    spr_we   = 1'b0;
    spr_wa   = cmd.index[SPR_AW-1:0];
    spr_wd   = '{damping: cmd.damping, stiffness: cmd.stiffness,
                 brk: cmd.break_length, rest: cmd.rest_length,
                 n2: cmd.spring_ends[2*NODE_AW-1:NODE_AW],
                 n1: cmd.spring_ends[NODE_AW-1:0]};
    spr_ra   = cnt[SPR_AW-1:0];
    ds_start = 1'b0;
    ds_req   = '{is_sqrt: 1'b0, rad: sq_a + prod, dvd: frc_cur.fx,
                 dvs: {1'b0, mass}};
    unique case (state)
      ST_IDLE: begin
        if (cmd_acc && cmd.op == OP_NODE && {1'b0, cmd.index} < 8'(MAX_NODES))
          node_we = 1'b1;
        if (cmd_acc && cmd.op == OP_SPRING && {1'b0, cmd.index} < 8'(MAX_SPRINGS))
          spr_we = 1'b1;
      end
      N_LD: begin
        ds_start = 1'b1;
        ds_req.dvs = {1'b0, node_rd.mass};
      end
      N_DX: begin
        ds_start   = ds_rsp.done;
        ds_req.dvd = fry;
      end
      N_WR: begin
        node_we = 1'b1;
        node_wa = cnt[NODE_AW-1:0];
        node_wd = '{mass: mass, vel_y: vy, vel_x: vx, pos_y: py, pos_x: px};
        frc_we  = 1'b1;
      end
      S_LD:  node_ra = spr_rd.n1;
      S_N1:  node_ra = spr.n2;
      S_Q3: begin
        ds_start       = 1'b1;
        ds_req.is_sqrt = 1'b1;
      end
      S_BRK: begin
        ds_start   = !({1'b0, len} > {2'b00, spr.brk});
        ds_req.dvd = dx;
        ds_req.dvs = len;
      end
      S_UX: begin
        ds_start   = ds_rsp.done;
        ds_req.dvd = dy;
        ds_req.dvs = len;
      end
      C_RD:  spr_ra = jdx + SPR_AW'(1);
      C_WR: begin
        spr_we = 1'b1;
        spr_wa = jdx;
        spr_wd = spr_rd;
      end
      S_E7:  frc_ra = spr.n2;
      S_E8: begin
        frc_we = 1'b1;
        frc_wa = spr.n2;
        frc_wd = '{fy: sat_add(frc_cur.fy, pq), fx: sat_add(frc_cur.fx, fx)};
      end
      S_E9:  frc_ra = spr.n1;
      S_E10: begin
        frc_we = 1'b1;
        frc_wa = spr.n1;
        frc_wd = '{fy: sat_sub(frc_cur.fy, fy_new), fx: sat_sub(frc_cur.fx, fx)};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= 7'd0;
      gravity    <= 32'sd642253;
      term_speed <= 31'd3276800;
      time_step  <= 31'd1092;
      active     <= 8'd0;
      frc_vld    <= '0;
      r_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_NODE_COUNT: node_count <= cfg.data[6:0];
          REG_GRAVITY:    gravity    <= cfg.data;
          REG_TERM_SPEED: term_speed <= cfg.data[30:0];
          REG_TIME_STEP:  time_step  <= cfg.data[30:0];
          default: ;
        endcase
      end
      if (frc_we) frc_vld[frc_wa] <= 1'b1;

      unique case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            unique case (op_t'(cmd.op))
              OP_NODE: begin
                if ({1'b0, cmd.index} < 8'(MAX_NODES))
                  frc_vld[cmd.index[NODE_AW-1:0]] <= 1'b0;
              end
              OP_SPRING: begin
                if ({1'b0, cmd.index} < 8'(MAX_SPRINGS) && active < {1'b0, cmd.index} + 8'd1)
                  active <= {1'b0, cmd.index} + 8'd1;
              end
              OP_STEP: begin
                cnt   <= '0;
                state <= N_RD;
              end
              default: ;
            endcase
          end
        end

        // node pass: integrate, then weight and terminal speed
        N_RD: state <= (cnt == {1'b0, nc}) ? S_RD : N_LD;
        N_LD: begin
          px    <= node_rd.pos_x;
          py    <= node_rd.pos_y;
          vx    <= node_rd.vel_x;
          vy    <= node_rd.vel_y;
          mass  <= node_rd.mass;
          fry   <= frc_cur.fy;
          state <= N_DX;
        end
        N_DX: if (ds_rsp.done) begin ax <= ds_rsp.res; state <= N_DY; end
        N_DY: if (ds_rsp.done) begin ay <= ds_rsp.res; state <= N_M1; end
        N_M1: state <= N_M2;
        N_M2: begin vx <= sat_add(vx, pq); state <= N_M3; end
        N_M3: begin vy <= sat_add(vy, pq); state <= N_M4; end
        N_M4: begin px <= sat_add(px, pq); state <= N_M5; end
        N_M5: begin py <= sat_add(py, pq); state <= N_M6; end
        N_M6: begin
          fy_new <= sat_sub('0, pq);
          if ($signed({vy[31], vy}) <= neg_term) vy <= neg_term[31:0];
          state <= N_WR;
        end
        N_WR: begin
          cnt   <= cnt + 8'd1;
          state <= N_RD;
          if (cnt + 8'd1 == {1'b0, nc}) cnt <= '0;
          if (cnt + 8'd1 == {1'b0, nc}) state <= S_RD;
        end

        // spring pass
        S_RD: begin
          if (cnt == active) begin
            cnt   <= '0;
            state <= O_RD;
          end else begin
            state <= S_LD;
          end
        end
        S_LD: begin spr <= spr_rd; state <= S_N1; end
        S_N1: begin
          px    <= node_rd.pos_x;
          py    <= node_rd.pos_y;
          vx    <= node_rd.vel_x;
          vy    <= node_rd.vel_y;
          state <= S_N2;
        end
        S_N2: begin
          dx    <= sat_sub(px, node_rd.pos_x);
          dy    <= sat_sub(py, node_rd.pos_y);
          rvx   <= sat_sub(vx, node_rd.vel_x);
          rvy   <= sat_sub(vy, node_rd.vel_y);
          state <= S_Q1;
        end
        S_Q1: state <= S_Q2;
        S_Q2: begin sq_a <= prod; state <= S_Q3; end
        S_Q3: state <= S_SQ;
        S_SQ: if (ds_rsp.done) begin len <= ds_rsp.res; state <= S_BRK; end
        S_BRK: begin
          if ({1'b0, len} > {2'b00, spr.brk}) begin
            // broken: close the gap, then evaluate the entry moved in
            if (cnt + 8'd1 < active) begin
              jdx   <= cnt[SPR_AW-1:0];
              state <= C_RD;
            end else begin
              active <= active - 8'd1;
              state  <= S_RD;
            end
          end else begin
            state <= S_UX;
          end
        end
        C_RD: state <= C_WR;
        C_WR: begin
          jdx <= jdx + SPR_AW'(1);
          if ({1'b0, jdx} + 8'd2 < active) begin
            state <= C_RD;
          end else begin
            active <= active - 8'd1;
            state  <= S_RD;
          end
        end
        S_UX: if (ds_rsp.done) begin ux <= ds_rsp.res; state <= S_UY; end
        S_UY: if (ds_rsp.done) begin uy <= ds_rsp.res; state <= S_E1; end
        S_E1: begin
          comp  <= sat33($signed({1'b0, len}) - $signed({2'b00, spr.rest}));
          state <= S_E2;
        end
        S_E2: begin tmp <= pq; state <= S_E3; end
        S_E3: begin dot <= sat_add(tmp, pq); state <= S_E4; end
        S_E4: begin tmp <= pq; state <= S_E5; end
        S_E5: begin f <= sat_add(tmp, pq); state <= S_E6; end
        S_E6: state <= S_E7;
        S_E7: begin fx <= pq; state <= S_E8; end
        S_E8: begin fy_new <= pq; state <= S_E9; end
        S_E9: state <= S_E10;
        S_E10: begin cnt <= cnt + 8'd1; state <= S_RD; end

        // report every node in use
        O_RD: state <= (cnt == {1'b0, nc}) ? ST_IDLE : O_LD;
        O_LD: begin
          r_valid <= 1'b1;
          r_index <= cnt[NODE_AW-1:0];
          r_node  <= node_rd;
          r_live  <= active;
          r_last  <= (cnt + 8'd1 == {1'b0, nc});
          state   <= O_WT;
        end
        O_WT: begin
          if (res.ready) begin
            r_valid <= 1'b0;
            cnt     <= cnt + 8'd1;
            state   <= O_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: dv/msp_step_checker.sv
// Checker for mass_spring_step: mirrors the node and spring tables, predicts
// every node report of a step and compares them with the result channel.
// Depends on msp_pkg and the msp_cmd_if, msp_res_if and msp_cfg_if interfaces.
module msp_step_checker import msp_pkg::*; (
  input  logic clk,
  input  logic rst,
  msp_cmd_if   cmd,
  msp_res_if   res,
  msp_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  typedef struct {
    logic [5:0]  node;
    logic [31:0] px, py, vx, vy;
    logic [7:0]  live;
    logic        last;
  } node_report_t;

  typedef struct {
    int     a, b;
    longint rest, brk, stiff, damp;
  } link_t;

  node_report_t reports_due[$];

  longint px[MAX_NODES], py[MAX_NODES], vx[MAX_NODES], vy[MAX_NODES];
  longint fx[MAX_NODES], fy[MAX_NODES], mass[MAX_NODES];
  link_t  links[MAX_SPRINGS];
  int     live_links;
  int     nodes_used;
  longint grav, vmax, dt;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product scaled down by 2^16, floor
  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat32(p >>> 16);
  endfunction

  // ratio scaled up by 2^16, truncated toward zero
  function automatic longint fdiv(longint a, longint b);
    if (b == 0) return 0;
    return sat32((a * 65536) / b);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < MAX_NODES; i++) begin
      px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
      fx[i] = 0; fy[i] = 0; mass[i] = 0;
    end
    for (int i = 0; i < MAX_SPRINGS; i++) links[i] = '{0, 0, 0, 0, 0, 0};
    live_links = 0;
    nodes_used = 0;
    grav = 642253;
    vmax = 3276800;
    dt   = 1092;
  endfunction

  // Hooke plus damping along the unit direction
  function automatic void pull_link(link_t s, longint len, longint dx, longint dy);
    longint ux, uy, comp, rvx, rvy, dot, f, gx, gy;
    ux   = fdiv(dx, len);
    uy   = fdiv(dy, len);
    comp = sat32(len - s.rest);
    rvx  = sat32(vx[s.a] - vx[s.b]);
    rvy  = sat32(vy[s.a] - vy[s.b]);
    dot  = sat32(fmul(rvx, ux) + fmul(rvy, uy));
    f    = sat32(fmul(comp, s.stiff) + fmul(dot, s.damp));
    gx   = fmul(ux, f);
    gy   = fmul(uy, f);
    fx[s.b] = sat32(fx[s.b] + gx);
    fy[s.b] = sat32(fy[s.b] + gy);
    fx[s.a] = sat32(fx[s.a] - gx);
    fy[s.a] = sat32(fy[s.a] - gy);
  endfunction

  function automatic void run_step();
    int nc, i;
    longint ax, ay, dx, dy, len;
    longint unsigned sq;
    node_report_t r;
    nc = (nodes_used > MAX_NODES) ? MAX_NODES : nodes_used;
    for (i = 0; i < nc; i++) begin
      ax = fdiv(fx[i], mass[i]);
      ay = fdiv(fy[i], mass[i]);
      fx[i] = 0;
      fy[i] = 0;
      vx[i] = sat32(vx[i] + fmul(ax, dt));
      vy[i] = sat32(vy[i] + fmul(ay, dt));
      px[i] = sat32(px[i] + fmul(vx[i], dt));
      py[i] = sat32(py[i] + fmul(vy[i], dt));
    end
    for (i = 0; i < nc; i++) begin
      fy[i] = sat32(fy[i] - fmul(mass[i], grav));
      if (vy[i] <= -vmax) vy[i] = -vmax;
    end
    i = 0;
    while (i < live_links && i < MAX_SPRINGS) begin
      dx  = sat32(px[links[i].a] - px[links[i].b]);
      dy  = sat32(py[links[i].a] - py[links[i].b]);
      sq  = longint'(dx * dx) + longint'(dy * dy);
      len = longint'(root_floor(sq));
      if (len > links[i].brk) begin
        // broken: close the gap, the entry moved down is handled next
        for (int j = i; j + 1 < live_links && j + 1 < MAX_SPRINGS; j++)
          links[j] = links[j + 1];
        live_links--;
      end else begin
        pull_link(links[i], len, dx, dy);
        i++;
      end
    end
    for (i = 0; i < nc; i++) begin
      r.node = i[5:0];
      r.px   = px[i][31:0];
      r.py   = py[i][31:0];
      r.vx   = vx[i][31:0];
      r.vy   = vy[i][31:0];
      r.live = live_links[7:0];
      r.last = (i + 1 == nc);
      reports_due.push_back(r);
    end
  endfunction

  function automatic void check_field(string f, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, f, e, a);
    end
  endfunction

  initial begin
    errors = 0;
    clear_model();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      reports_due.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: node report for node %0d with none pending", $realtime,
                     res.node_index);
        end else begin
          node_report_t e;
          e = reports_due.pop_front();
          check_field("node_index", e.node, res.node_index);
          check_field("out_pos_x", e.px, res.out_pos_x);
          check_field("out_pos_y", e.py, res.out_pos_y);
          check_field("out_vel_x", e.vx, res.out_vel_x);
          check_field("out_vel_y", e.vy, res.out_vel_y);
          check_field("live_springs", e.live, res.live_springs);
          check_field("last", e.last, res.last);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_NODE_COUNT: nodes_used = cfg.data[6:0];
          REG_GRAVITY:    grav = longint'($signed(cfg.data));
          REG_TERM_SPEED: vmax = longint'(cfg.data[30:0]);
          REG_TIME_STEP:  dt   = longint'(cfg.data[30:0]);
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.op)
          OP_NODE: if (cmd.index < MAX_NODES) begin
            px[cmd.index]   = longint'(cmd.pos_x);
            py[cmd.index]   = longint'(cmd.pos_y);
            vx[cmd.index]   = longint'(cmd.vel_x);
            vy[cmd.index]   = longint'(cmd.vel_y);
            mass[cmd.index] = longint'(cmd.mass);
            fx[cmd.index]   = 0;
            fy[cmd.index]   = 0;
          end
          OP_SPRING: if (cmd.index < MAX_SPRINGS) begin
            links[cmd.index].a     = cmd.spring_ends[5:0];
            links[cmd.index].b     = cmd.spring_ends[11:6];
            links[cmd.index].rest  = longint'(cmd.rest_length);
            links[cmd.index].brk   = longint'(cmd.break_length);
            links[cmd.index].stiff = longint'(cmd.stiffness);
            links[cmd.index].damp  = longint'(cmd.damping);
            if (live_links < cmd.index + 1) live_links = cmd.index + 1;
          end
          OP_STEP: run_step();
          default: ;
        endcase
      end
    end
    pending <= reports_due.size();
  end

endmodule

// File: dv/tb_top.sv
// Top of the mass_spring_step testbench: clock, reset, item stimulus and
// register writes, receiver stalls and the verdict.
// Depends on msp_pkg, the three channel interfaces and msp_step_checker.
module tb_top;
  import msp_pkg::*;

  // op code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [6:0]  idx;
    logic [31:0] px, py, vx, vy;
    logic [30:0] mass;
    logic [11:0] ends;
    logic [30:0] rest, brk;
    logic [31:0] stiff, damp;
  } soft_item_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;

  msp_cmd_if cmd ();
  msp_res_if res ();
  msp_cfg_if cfg ();

  mass_spring_step uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .cfg (cfg)
  );

  msp_step_checker chk (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res     (res),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  // tables fill from the bottom: nodes 0..node_prefix-1 and springs
  // 0..link_hwm-1 have been written, so no step reads a blank entry
  int node_prefix = 0;
  int link_hwm    = 0;
  int burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: modes of always ready, random stalls and long stalls
  int stall_mode, mode_left, hold_left;
  always @(posedge clk) begin
    if (rst) begin
      stall_mode <= 0;
      mode_left  <= 100;
      hold_left  <= 0;
      res.ready  <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= $urandom_range(0, 1);
        default: begin
          if (hold_left == 0) begin
            hold_left <= $urandom_range(1, 20);
            res.ready <= ~res.ready;
          end else begin
            hold_left <= hold_left - 1;
          end
        end
      endcase
    end
  end

  // small magnitudes and full range, each four times in ten; extremes otherwise
  function automatic logic [31:0] rnd_q();
    int s;
    logic [31:0] v;
    s = $urandom_range(0, 9);
    if (s < 4) begin
      v = $urandom_range(0, 32'h0004_0000);
      if ($urandom_range(0, 1)) v = -v;
    end else if (s < 6) begin
      case ($urandom_range(0, 4))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        3: v = 32'h0000_0001;
        default: v = 32'hffff_ffff;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic soft_item_t node_item(int i, logic [31:0] px, logic [31:0] py,
                                           logic [31:0] vx, logic [31:0] vy,
                                           logic [30:0] m);
    soft_item_t c;
    c = '{default: '0};
    c.op = OP_NODE; c.idx = i;
    c.px = px; c.py = py; c.vx = vx; c.vy = vy; c.mass = m;
    c.rest = $urandom; c.stiff = $urandom;
    return c;
  endfunction

  function automatic soft_item_t link_item(int i, int a, int b, logic [30:0] rl,
                                           logic [30:0] bl, logic [31:0] k,
                                           logic [31:0] d);
    soft_item_t c;
    c = '{default: '0};
    c.op = OP_SPRING; c.idx = i;
    c.ends = {b[5:0], a[5:0]};
    c.rest = rl; c.brk = bl; c.stiff = k; c.damp = d;
    c.px = $urandom; c.mass = $urandom;
    return c;
  endfunction

  function automatic soft_item_t bare_item(logic [1:0] op);
    soft_item_t c;
    c = '{default: '0};
    c.op = op;
    c.idx = $urandom; c.px = $urandom; c.ends = $urandom;
    return c;
  endfunction

  function automatic soft_item_t random_item();
    int s, i;
    logic [30:0] bl;
    s = $urandom_range(0, 99);
    if (s < 35) begin
      // node write, now and then beyond the table
      if ($urandom_range(0, 9) == 0) i = $urandom_range(MAX_NODES, 127);
      else i = $urandom_range(0, (node_prefix < MAX_NODES) ? node_prefix : MAX_NODES - 1);
      return node_item(i, rnd_q(), rnd_q(), rnd_q(), rnd_q(),
                       ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                                                     31'($urandom_range(1, 32'h0010_0000)));
    end else if (s < 65) begin
      i = $urandom_range(0, (link_hwm < MAX_SPRINGS) ? link_hwm : MAX_SPRINGS - 1);
      case ($urandom_range(0, 3))
        0: bl = $urandom_range(0, 32'h0004_0000);
        1: bl = 31'h7fff_ffff;
        default: bl = $urandom;
      endcase
      return link_item(i, $urandom_range(0, node_prefix - 1),
                       $urandom_range(0, node_prefix - 1),
                       31'(rnd_q()), bl, rnd_q(), rnd_q());
    end else if (s < 95) begin
      return bare_item(OP_STEP);
    end
    return bare_item(OP_UNUSED);
  endfunction

  // sender: bursts of random length with random gaps
  task automatic send_item(soft_item_t c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        cmd.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 6);
    end
    cmd.valid        <= 1'b1;
    cmd.op           <= c.op;
    cmd.index        <= c.idx;
    cmd.pos_x        <= c.px;
    cmd.pos_y        <= c.py;
    cmd.vel_x        <= c.vx;
    cmd.vel_y        <= c.vy;
    cmd.mass         <= c.mass;
    cmd.spring_ends  <= c.ends;
    cmd.rest_length  <= c.rest;
    cmd.break_length <= c.brk;
    cmd.stiffness    <= c.stiff;
    cmd.damping      <= c.damp;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    burst_left--;
    if (c.op == OP_NODE && c.idx == node_prefix && c.idx < MAX_NODES) node_prefix++;
    if (c.op == OP_SPRING && c.idx + 1 > link_hwm) link_hwm = c.idx + 1;
  endtask

  // drain: all reports in, then room for a step that reports nothing
  task automatic wait_idle();
    cmd.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300 + 140 * link_hwm + 120 * node_prefix) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= r;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] nc, logic [31:0] g, logic [30:0] ts,
                            logic [30:0] dts);
    write_reg(REG_NODE_COUNT, nc);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_TERM_SPEED, {1'($urandom), ts});
    write_reg(REG_TIME_STEP, {1'($urandom), dts});
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] count_word(int n);
    return {25'($urandom), 7'(n)};
  endfunction

  initial begin
    cmd.valid <= 1'b0;
    cmd.op <= OP_NODE; cmd.index <= '0;
    cmd.pos_x <= '0; cmd.pos_y <= '0; cmd.vel_x <= '0; cmd.vel_y <= '0;
    cmd.mass <= '0; cmd.spring_ends <= '0; cmd.rest_length <= '0;
    cmd.break_length <= '0; cmd.stiffness <= '0; cmd.damping <= '0;
    cfg.valid <= 1'b0; cfg.index <= REG_NODE_COUNT; cfg.data <= '0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty step with no nodes in use, then an ignored op
    send_item(bare_item(OP_STEP));
    send_item(bare_item(OP_UNUSED));
    // extremes, zero mass, two coincident nodes
    send_item(node_item(0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        31'h7fff_ffff));
    send_item(node_item(1, 32'hfff0_0000, 32'h0002_0000, 32'h0000_8000, 32'hffff_0000,
                        31'd0));
    send_item(node_item(2, 32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0000_2000,
                        31'h0001_0000));
    send_item(node_item(3, 32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0000_2000,
                        31'h0002_0000));
    // node writes beyond the table are dropped
    send_item(node_item(127, '1, '1, '1, '1, '1));
    send_item(node_item(MAX_NODES, '0, '0, '0, '0, 31'd1));
    send_item(link_item(0, 0, 1, 31'h0001_0000, 31'h7fff_ffff, 32'h0001_0000,
                        32'h0000_4000));
    // zero length, same node at both ends
    send_item(link_item(1, 2, 3, 31'd0, 31'h7fff_ffff, 32'h0010_0000, 32'h0001_0000));
    send_item(link_item(2, 2, 2, 31'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000));
    // breaks at once; the next entry slides down and is evaluated
    send_item(link_item(3, 1, 2, 31'd0, 31'd0, 32'h0001_0000, 32'h0001_0000));
    send_item(link_item(4, 0, 3, 31'h0000_8000, 31'h7fff_ffff, 32'h8000_0000,
                        32'h7fff_ffff));
    send_item(bare_item(OP_STEP));
    wait_idle();
    write_regs(count_word(4), 32'd642253, 31'd3276800, 31'd1092);
    repeat (3) send_item(bare_item(OP_STEP));
    wait_idle();

    // random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_regs(count_word(node_prefix), rnd_q(), 31'h7fff_ffff,
                      $urandom_range(0, 4000));
        1: write_regs(count_word($urandom_range(0, node_prefix)), 32'h8000_0000,
                      31'd0, 31'd0);
        2: write_regs(count_word($urandom_range(0, node_prefix)), 32'h7fff_ffff,
                      $urandom, 31'h7fff_ffff);
        3: write_regs(count_word($urandom_range(0, node_prefix)), 32'd0,
                      $urandom, $urandom_range(0, 70000));
        default: write_regs(count_word($urandom_range(0, node_prefix)), rnd_q(),
                            $urandom, $urandom_range(0, 20000));
      endcase
      repeat (18) send_item(random_item());
      wait_idle();
    end

    // fill the node table, then run with every node in use
    while (node_prefix < MAX_NODES)
      send_item(node_item(node_prefix, rnd_q(), rnd_q(), rnd_q(), rnd_q(),
                          $urandom_range(1, 32'h0010_0000)));
    wait_idle();
    write_regs(count_word(MAX_NODES), rnd_q(), $urandom_range(0, 32'h0040_0000),
               $urandom_range(0, 3000));
    send_item(link_item(0, 63, 0, 31'h0001_0000, 31'h7fff_ffff, rnd_q(), rnd_q()));
    repeat (2) send_item(bare_item(OP_STEP));
    wait_idle();
    // count above the table size acts as a full table
    write_regs(count_word(127), $urandom, $urandom, $urandom_range(0, 3000));
    send_item(bare_item(OP_STEP));
    wait_idle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
